/* sv/pbrle_pkg.sv */
package pbrle_pkg;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_WORD_W  = 64;
  localparam int unsigned OUT_CNT_W   = 4;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [7:0] END_MARKER = 8'd128;
  localparam logic [8:0] RUN_BASE   = 9'd257;

  // One command from the encoder sequencer to the output packer.
  typedef struct packed {
    logic       push_byte;
    logic [7:0] byte_val;
    logic       end_group;
    logic       stream_done;
  } pack_cmd_t;

endpackage

/* sv/pbrle_pack.sv */
module pbrle_pack #(
  parameter int unsigned OUT_LANES = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pbrle_pkg::pack_cmd_t               cmd,
  output logic                               stall,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pbrle_pkg::OUT_TDATA_W-1:0]  out_tdata,  // out_word[63:0], byte_count[67:64]
  output logic                               out_tlast,  // last_of_group
  output logic                               out_tuser   // stream_done
);
  import pbrle_pkg::*;

  localparam int unsigned CW = $clog2(OUT_LANES + 1);
  localparam int unsigned WW = OUT_LANES * 8;

  logic [WW-1:0]         word_r, word_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_WORD_W-1:0] out_word_r;
  logic [OUT_CNT_W-1:0]  out_cnt_r;
  logic                  out_last_r, out_done_r;

  logic          push_full, push_end, push;
  logic [CW-1:0] sel;

  assign push_full = cmd.push_byte && (cnt_r == CW'(OUT_LANES));
  assign push_end  = cmd.end_group && (cnt_r != '0);
  assign push      = push_full || push_end;
  assign stall     = push && out_valid_r && !out_tready;
  assign sel       = push_full ? '0 : cnt_r;

  always_comb begin
    word_nxt      = word_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (!stall) begin
      if (cmd.push_byte) begin
        if (push_full) begin
          word_nxt = '0;
        end
        for (int i = 0; i < OUT_LANES; i++) begin
          if (sel == CW'(i)) begin
            word_nxt[i*8 +: 8] = cmd.byte_val;
          end
        end
        cnt_nxt = sel + CW'(1);
      end else if (cmd.end_group) begin
        word_nxt = '0;
        cnt_nxt  = '0;
      end
      if (push) begin
        out_valid_nxt = 1'b1;
      end else if (out_tready) begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      word_r      <= word_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !stall) begin
      out_word_r <= OUT_WORD_W'(word_r);
      out_cnt_r  <= OUT_CNT_W'(cnt_r);
      out_last_r <= push_end;
      out_done_r <= push_end && cmd.stream_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_WORD_W - OUT_CNT_W)'(0), out_cnt_r, out_word_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule

/* sv/packbits_run_length_encoder.sv */
// PackBits encoder for a byte stream. Each input transfer carries one raw byte, with tlast on
// the final byte of a stream; each output transfer carries up to OUT_LANES encoded bytes
// (first byte in the lowest lane, count in tdata[67:64]), tlast on the last transfer caused by
// an input byte and tuser on the transfer that ends with the end marker 128. The block works
// on one byte at a time: each byte passes through the first, last and done states, plus a
// run header and run byte for each run it closes and a header and the data for each literal
// block it flushes; the last byte of a stream also flushes the buffer and sends the end
// marker. A single sequencer emits one encoded byte per cycle into the output packer and
// reads the literal buffer memory one entry per cycle while not stalled; a full output
// register that is not taken stalls it. The literal buffer needs no clearing after reset.
module packbits_run_length_encoder #(
  parameter int unsigned MAX_GROUP = 128,
  parameter int unsigned OUT_LANES = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pbrle_pkg::IN_TDATA_W-1:0]   in_tdata,   // data_byte[7:0]
  input  logic                               in_tlast,   // stream_last
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pbrle_pkg::OUT_TDATA_W-1:0]  out_tdata,  // out_word[63:0], byte_count[67:64]
  output logic                               out_tlast,  // last_of_group
  output logic                               out_tuser   // stream_done
);
  import pbrle_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_GROUP);
  localparam int unsigned RLW = $clog2(MAX_GROUP + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIRST = 4'd1;
  localparam logic [3:0] S_LAST  = 4'd2;
  localparam logic [3:0] S_ENDFL = 4'd3;
  localparam logic [3:0] S_RUN_H = 4'd4;
  localparam logic [3:0] S_RUN_B = 4'd5;
  localparam logic [3:0] S_FL_H  = 4'd6;
  localparam logic [3:0] S_FL_D  = 4'd7;
  localparam logic [3:0] S_MARK  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]     state_r, state_nxt;
  logic [3:0]     ret_r, ret_nxt;
  logic [7:0]     b_r, b_nxt;
  logic           last_r, last_nxt;
  logic [7:0]     pb_r, pb_nxt;
  logic           pv_r, pv_nxt;
  logic [RLW-1:0] rl_r, rl_nxt;
  logic [RLW-1:0] lc_r, lc_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [RLW-1:0] runlen_r, runlen_nxt;
  logic [7:0]     runbyte_r, runbyte_nxt;

  logic [7:0]     lit_mem [MAX_GROUP];
  logic [7:0]     mem_q;
  logic           lit_we;
  logic [AW-1:0]  rd_addr;

  pack_cmd_t cmd;
  logic      stall, adv, eq;

  assign adv       = !stall;
  assign in_tready = (state_r == S_IDLE);
  assign eq        = pv_r && (b_r == pb_r);

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    b_nxt       = b_r;
    last_nxt    = last_r;
    pb_nxt      = pb_r;
    pv_nxt      = pv_r;
    rl_nxt      = rl_r;
    lc_nxt      = lc_r;
    idx_nxt     = idx_r;
    runlen_nxt  = runlen_r;
    runbyte_nxt = runbyte_r;
    lit_we      = 1'b0;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          b_nxt     = in_tdata[7:0];
          last_nxt  = in_tlast;
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        if (eq) begin
          if (rl_r >= RLW'(MAX_GROUP)) begin
            // Full run: send it and keep the new byte as a held group of one.
            runlen_nxt  = rl_r;
            runbyte_nxt = pb_r;
            rl_nxt      = RLW'(1);
            ret_nxt     = S_LAST;
            state_nxt   = S_RUN_H;
          end else if (rl_r == RLW'(1)) begin
            rl_nxt    = RLW'(2);
            ret_nxt   = S_LAST;
            state_nxt = S_FL_H;
          end else begin
            rl_nxt    = rl_r + RLW'(1);
            state_nxt = S_LAST;
          end
        end else begin
          pb_nxt = b_r;
          pv_nxt = 1'b1;
          rl_nxt = RLW'(1);
          if (pv_r && rl_r >= RLW'(2)) begin
            runlen_nxt  = rl_r;
            runbyte_nxt = pb_r;
            ret_nxt     = S_LAST;
            state_nxt   = S_RUN_H;
          end else if (pv_r) begin
            lit_we = 1'b1;
            lc_nxt = lc_r + RLW'(1);
            if (lc_nxt == RLW'(MAX_GROUP)) begin
              ret_nxt   = S_LAST;
              state_nxt = S_FL_H;
            end else begin
              state_nxt = S_LAST;
            end
          end else begin
            state_nxt = S_LAST;
          end
        end
      end
      S_LAST: begin
        if (last_r) begin
          pv_nxt = 1'b0;
          rl_nxt = '0;
          if (rl_r >= RLW'(2)) begin
            runlen_nxt  = rl_r;
            runbyte_nxt = pb_r;
            ret_nxt     = S_ENDFL;
            state_nxt   = S_RUN_H;
          end else begin
            // The buffer cannot be full here, and it is flushed next anyway.
            lit_we    = 1'b1;
            lc_nxt    = lc_r + RLW'(1);
            state_nxt = S_ENDFL;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ENDFL: begin
        ret_nxt   = S_MARK;
        state_nxt = S_FL_H;
      end
      S_RUN_H: begin
        cmd.push_byte = 1'b1;
        cmd.byte_val  = 8'(RUN_BASE - 9'(runlen_r));
        state_nxt     = S_RUN_B;
      end
      S_RUN_B: begin
        cmd.push_byte = 1'b1;
        cmd.byte_val  = runbyte_r;
        state_nxt     = ret_r;
      end
      S_FL_H: begin
        if (lc_r == '0) begin
          state_nxt = ret_r;
        end else begin
          cmd.push_byte = 1'b1;
          cmd.byte_val  = 8'(lc_r - RLW'(1));
          idx_nxt       = '0;
          state_nxt     = S_FL_D;
        end
      end
      S_FL_D: begin
        cmd.push_byte = 1'b1;
        cmd.byte_val  = mem_q;
        if (RLW'(idx_r) + RLW'(1) == lc_r) begin
          lc_nxt    = '0;
          state_nxt = ret_r;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_MARK: begin
        cmd.push_byte = 1'b1;
        cmd.byte_val  = END_MARKER;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        cmd.end_group   = 1'b1;
        cmd.stream_done = last_r;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Reads run one entry ahead of the byte being sent; a stall re-reads the current entry.
  always_comb begin
    if (state_r == S_FL_D) begin
      rd_addr = adv ? idx_r + AW'(1) : idx_r;
    end else begin
      rd_addr = '0;
    end
  end

  // Writes and reads never target the same cycle: the sequencer always writes the buffer
  // at least one state before it starts a flush.
  always_ff @(posedge clk) begin
    if (lit_we && adv) begin
      lit_mem[lc_r[AW-1:0]] <= pb_r;
    end
    mem_q <= lit_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      pv_r    <= 1'b0;
      pb_r    <= '0;
      rl_r    <= '0;
      lc_r    <= '0;
      idx_r   <= '0;
      last_r  <= 1'b0;
    end else if (adv) begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      pv_r    <= pv_nxt;
      pb_r    <= pb_nxt;
      rl_r    <= rl_nxt;
      lc_r    <= lc_nxt;
      idx_r   <= idx_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_r       <= b_nxt;
      runlen_r  <= runlen_nxt;
      runbyte_r <= runbyte_nxt;
    end
  end

  pbrle_pack #(
    .OUT_LANES (OUT_LANES)
  ) u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stall      (stall),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_idle_buf_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (lc_r < RLW'(MAX_GROUP)))
    else $error("literal buffer left full between bytes");

  a_idle_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && pv_r) |-> (rl_r != '0 && rl_r <= RLW'(MAX_GROUP)))
    else $error("held run length out of range");

  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FL_D) |-> (lc_r != '0 && RLW'(idx_r) < lc_r))
    else $error("literal flush past buffer fill");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (lit_we && adv) |-> (lc_r < RLW'(MAX_GROUP)))
    else $error("literal write beyond buffer");

  a_stream_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && last_r && adv) |=> (!pv_r && lc_r == '0))
    else $error("state not cleared at end of stream");

endmodule

/* verif/packbits_run_length_encoder_checker.sv */
module packbits_run_length_encoder_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [pbrle_pkg::IN_TDATA_W-1:0]  in_tdata,   // data_byte[7:0]
  input  logic                              in_tlast,   // stream_last
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [pbrle_pkg::OUT_TDATA_W-1:0] out_tdata,  // out_word[63:0], byte_count[67:64]
  input  logic                              out_tlast,  // last_of_group
  input  logic                              out_tuser,  // stream_done
  output int                                error_count,
  output int                                expected_left
);
  import pbrle_pkg::*;

  localparam int unsigned GROUP_MAX = 128;
  localparam int unsigned LANES     = 8;

  typedef struct {
    logic [OUT_WORD_W-1:0] word;
    logic [OUT_CNT_W-1:0]  count;
    logic                  grp_last;
    logic                  done;
  } code_word_t;

  code_word_t  pending_words[$];
  logic [7:0]  code_bytes[$];

  // Encoder state: the held byte with its repeat count, and the literal buffer.
  logic [7:0]  held_byte;
  logic        held_valid;
  int unsigned held_run;
  logic [7:0]  lit_buf[GROUP_MAX];
  int unsigned lit_cnt;

  task automatic report_mismatch(input string what);
    if (error_count < 100) begin
      $display("mismatch at %0t: %s", $time, what);
    end
    error_count++;
  endtask

  function automatic void put_code_byte(input logic [7:0] b);
    code_bytes.insert(code_bytes.size(), b);
  endfunction

  function automatic void flush_literal_block();
    if (lit_cnt == 0) return;
    put_code_byte(8'(lit_cnt - 1));
    for (int i = 0; i < lit_cnt; i++) begin
      put_code_byte(lit_buf[i]);
    end
    lit_cnt = 0;
  endfunction

  function automatic void add_literal_byte(input logic [7:0] b);
    if (lit_cnt < GROUP_MAX) begin
      lit_buf[lit_cnt] = b;
      lit_cnt++;
    end
    if (lit_cnt >= GROUP_MAX) flush_literal_block();
  endfunction

  function automatic void emit_run_pair(input int unsigned len);
    logic [8:0] hdr;
    hdr = RUN_BASE - 9'(len);
    put_code_byte(hdr[7:0]);
    put_code_byte(held_byte);
  endfunction

  function automatic void close_held_group();
    if (held_valid) begin
      if (held_run >= 2) emit_run_pair(held_run);
      else add_literal_byte(held_byte);
    end
    held_valid = 1'b0;
    held_run   = 0;
  endfunction

  // Works out the encoded bytes caused by one input byte and queues them as output words.
  function automatic void encode_byte(input logic [7:0] b, input logic stream_end);
    code_word_t  cw;
    int unsigned nwords;
    int unsigned lane;
    code_bytes.delete();
    if (held_valid && b == held_byte) begin
      if (held_run >= GROUP_MAX) begin
        emit_run_pair(held_run);
        held_run = 1;
      end else begin
        if (held_run == 1) flush_literal_block();
        held_run++;
      end
    end else begin
      close_held_group();
      held_byte  = b;
      held_valid = 1'b1;
      held_run   = 1;
    end
    if (stream_end) begin
      close_held_group();
      flush_literal_block();
      put_code_byte(END_MARKER);
    end
    nwords = (code_bytes.size() + LANES - 1) / LANES;
    for (int k = 0; k < nwords; k++) begin
      cw.word = '0;
      lane    = 0;
      while (lane < LANES && code_bytes.size() > 0) begin
        cw.word[8*lane +: 8] = code_bytes.pop_front();
        lane++;
      end
      cw.count    = OUT_CNT_W'(lane);
      cw.grp_last = (k == nwords - 1);
      cw.done     = stream_end && (k == nwords - 1);
      pending_words.insert(pending_words.size(), cw);
    end
  endfunction

  always @(posedge clk) begin
    code_word_t want;
    if (!rst_n) begin
      held_byte  = '0;
      held_valid = 1'b0;
      held_run   = 0;
      lit_cnt    = 0;
      pending_words.delete();
    end else begin
      // An output transfer can never be caused by an input accepted at the same edge.
      if (out_tvalid && out_tready) begin
        if (pending_words.size() == 0) begin
          report_mismatch($sformatf("unexpected output transfer, tdata %h", out_tdata));
        end else begin
          want = pending_words.pop_front();
          if (out_tdata[OUT_WORD_W-1:0] !== want.word) begin
            report_mismatch($sformatf("out_word %h, expected %h",
                                      out_tdata[OUT_WORD_W-1:0], want.word));
          end
          if (out_tdata[OUT_WORD_W +: OUT_CNT_W] !== want.count) begin
            report_mismatch($sformatf("byte_count %0d, expected %0d",
                                      out_tdata[OUT_WORD_W +: OUT_CNT_W], want.count));
          end
          if (out_tlast !== want.grp_last) begin
            report_mismatch($sformatf("last_of_group %b, expected %b",
                                      out_tlast, want.grp_last));
          end
          if (out_tuser !== want.done) begin
            report_mismatch($sformatf("stream_done %b, expected %b", out_tuser, want.done));
          end
        end
      end
      if (in_tvalid && in_tready) encode_byte(in_tdata, in_tlast);
    end
    expected_left = pending_words.size();
  end

endmodule

/* verif/packbits_run_length_encoder_test.sv */
module packbits_run_length_encoder_test;
  import pbrle_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int TOTAL_ITEMS   = 300;
  localparam int DRAIN_CYCLES  = 300;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;

  int error_count;
  int expected_left;
  int cycles = 0;

  logic [7:0] last_sent = 8'h00;
  int         sent_count = 0;
  int         burst_left = 1;

  logic [15:0] ready_pat = 16'hFFFF;
  int          pat_age = 0;

  packbits_run_length_encoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  packbits_run_length_encoder_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .error_count   (error_count),
    .expected_left (expected_left)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver rotates a stall pattern and now and then swaps it for a new one.
  always @(posedge clk) begin
    if (pat_age == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pat <= 16'hFFFF;
        1: ready_pat <= 16'($urandom) | 16'h0001;
        2: ready_pat <= 16'($urandom & $urandom) | 16'h8000;
        default: ready_pat <= 16'h0101;
      endcase
      pat_age <= $urandom_range(20, 200);
    end else begin
      ready_pat <= {ready_pat[0], ready_pat[15:1]};
      pat_age <= pat_age - 1;
    end
    out_tready <= ready_pat[0];
  end

  // Holds one byte on the input until its transfer, then maybe opens an idle gap.
  task automatic send_byte(input logic [7:0] dbyte, input logic is_last);
    int idle_gap;
    in_tvalid <= 1'b1;
    in_tdata  <= dbyte;
    in_tlast  <= is_last;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    last_sent = dbyte;
    sent_count++;
    burst_left--;
    if (burst_left <= 0) begin
      idle_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 16);
      if (idle_gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (idle_gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [7:0] fresh_byte();
    logic [7:0] b;
    do begin
      case ($urandom_range(0, 5))
        0: b = 8'h00;
        1: b = 8'hFF;
        2: b = END_MARKER;
        default: b = 8'($urandom_range(0, 255));
      endcase
    end while (b == last_sent);
    return b;
  endfunction

  task automatic send_run(input logic [7:0] dbyte, input int len, input logic stream_end);
    for (int i = 0; i < len; i++) begin
      send_byte(dbyte, stream_end && (i == len - 1));
    end
  endtask

  // Bytes that never repeat their neighbor, so they all land in the literal buffer.
  task automatic send_literal(input int len, input logic stream_end);
    for (int i = 0; i < len; i++) begin
      send_byte(fresh_byte(), stream_end && (i == len - 1));
    end
  endtask

  task automatic send_noise(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(0, 2) == 0) ? last_sent : 8'($urandom_range(0, 255));
      send_byte(b, $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic send_random_stream();
    int  nseg;
    logic fin;
    nseg = $urandom_range(1, 6);
    for (int s = 0; s < nseg; s++) begin
      fin = (s == nseg - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_literal($urandom_range(1, 6), fin);
        4, 5, 6:    send_run(fresh_byte(), $urandom_range(2, 8), fin);
        7:          send_run(fresh_byte(), $urandom_range(9, 40), fin);
        8: begin
          send_noise($urandom_range(1, 5));
          if (fin) send_byte(fresh_byte(), 1'b1);
        end
        default:    send_literal($urandom_range(7, 20), fin);
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-byte streams at the extremes of the byte range and at the end marker value.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(END_MARKER, 1'b1);
    // The shortest run, ending the stream.
    send_run(8'h55, 2, 1'b1);
    // Literals flushed by the start of a run.
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_run(8'h07, 3, 1'b1);
    // A single leftover byte at the end of the stream becomes a literal; the last case ends on a run.
    send_run(8'hAA, 3, 1'b0);
    send_byte(8'hBB, 1'b1);
    send_run(8'h10, 2, 1'b0);
    send_byte(8'h20, 1'b1);
    send_run(8'hFF, 2, 1'b0);
    send_run(8'h00, 2, 1'b1);

    // A full literal buffer, then a run of the group limit plus one whose extra byte is
    // left over at the end of the stream.
    send_literal(128, 1'b0);
    send_run(fresh_byte(), 129, 1'b1);
    while (sent_count < TOTAL_ITEMS) begin
      send_random_stream();
    end
    in_tvalid <= 1'b0;

    while (expected_left != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_left == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/pbrle_pkg.sv
sv/pbrle_pack.sv
sv/packbits_run_length_encoder.sv
verif/packbits_run_length_encoder_checker.sv
verif/packbits_run_length_encoder_test.sv
